// ----- hdl/srg_pkg.sv -----
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the stepper ramp generator
// Holds the register map, the configuration record and the coil tables.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int REM_W      = 27;
    localparam int DEN_W      = 27;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SPR       = 3'd1;
    localparam logic [2:0] REG_DIR       = 3'd2;
    localparam logic [2:0] REG_LENGTH    = 3'd3;
    localparam logic [2:0] REG_MIN_DELAY = 3'd4;
    localparam logic [2:0] REG_INIT_DLY  = 3'd5;
    localparam logic [2:0] REG_DEC_OFF   = 3'd6;

    localparam logic [1:0] MODE_DRIVER    = 2'd0;
    localparam logic [1:0] MODE_TWO_WIRE  = 2'd1;
    localparam logic [1:0] MODE_FOUR_WIRE = 2'd2;

    typedef struct packed {
        logic [1:0]         interface_mode;
        logic [15:0]        steps_per_rev;
        logic               move_direction;
        logic [23:0]        move_length;
        logic [23:0]        min_step_delay;
        logic [23:0]        initial_step_delay;
        logic signed [24:0] decel_offset;
    } t_cfg;

    function automatic logic [3:0] coil_pattern(input logic [1:0] mode,
                                                input logic [1:0] phase);
        logic [3:0] pat;
        pat = 4'd0;
        unique case (mode)
            MODE_TWO_WIRE: begin
                unique case (phase)
                    2'd0:    pat = 4'd2;
                    2'd1:    pat = 4'd3;
                    2'd2:    pat = 4'd1;
                    default: pat = 4'd0;
                endcase
            end
            MODE_FOUR_WIRE: begin
                unique case (phase)
                    2'd0:    pat = 4'd5;
                    2'd1:    pat = 4'd6;
                    2'd2:    pat = 4'd10;
                    default: pat = 4'd9;
                endcase
            end
            default: pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/srg_cfg.sv -----
// ----------------------------------------------------------------------------
// srg_cfg: configuration register file
// APB-style write and read access to the move and interface registers.
// ----------------------------------------------------------------------------
module srg_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output srg_pkg::t_cfg                   o_cfg
);

    srg_pkg::t_cfg r_cfg;
    logic          w_write;
    logic [2:0]    w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interface_mode     <= srg_pkg::MODE_DRIVER;
            r_cfg.steps_per_rev      <= 16'd200;
            r_cfg.move_direction     <= 1'b0;
            r_cfg.move_length        <= 24'd0;
            r_cfg.min_step_delay     <= 24'd1000;
            r_cfg.initial_step_delay <= 24'd1000;
            r_cfg.decel_offset       <= 25'sd0;
        end else if (w_write) begin
            unique case (w_index)
                srg_pkg::REG_MODE:      r_cfg.interface_mode     <= pwdata[1:0];
                srg_pkg::REG_SPR:       r_cfg.steps_per_rev      <= pwdata[15:0];
                srg_pkg::REG_DIR:       r_cfg.move_direction     <= pwdata[0];
                srg_pkg::REG_LENGTH:    r_cfg.move_length        <= pwdata[23:0];
                srg_pkg::REG_MIN_DELAY: r_cfg.min_step_delay     <= pwdata[23:0];
                srg_pkg::REG_INIT_DLY:  r_cfg.initial_step_delay <= pwdata[23:0];
                srg_pkg::REG_DEC_OFF:   r_cfg.decel_offset       <= $signed(pwdata[24:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            srg_pkg::REG_MODE:      prdata = {30'd0, r_cfg.interface_mode};
            srg_pkg::REG_SPR:       prdata = {16'd0, r_cfg.steps_per_rev};
            srg_pkg::REG_DIR:       prdata = {31'd0, r_cfg.move_direction};
            srg_pkg::REG_LENGTH:    prdata = {8'd0, r_cfg.move_length};
            srg_pkg::REG_MIN_DELAY: prdata = {8'd0, r_cfg.min_step_delay};
            srg_pkg::REG_INIT_DLY:  prdata = {8'd0, r_cfg.initial_step_delay};
            srg_pkg::REG_DEC_OFF:   prdata = {7'd0, r_cfg.decel_offset};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/srg_div.sv -----
// ----------------------------------------------------------------------------
// srg_div: shared iterative signed divider
// Restoring division, one quotient bit per cycle, truncating towards zero;
// the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module srg_div #(
    parameter int NUM_W = 30
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [NUM_W-1:0]           i_num,
    input  logic signed [srg_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [NUM_W-1:0]           o_quot,
    output logic signed [srg_pkg::REM_W-1:0]  o_rem
);

    localparam int MAG_W = NUM_W - 1;
    localparam int DM_W  = srg_pkg::DEN_W - 1;
    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_qneg;
    logic                        r_rneg;
    logic [MAG_W-1:0]            r_dvd;
    logic [DM_W-1:0]             r_dsr;
    logic [DM_W-1:0]             r_pr;
    logic [NUM_W-1:0]            w_num_abs;
    logic [srg_pkg::DEN_W-1:0]   w_den_abs;
    logic [DM_W:0]               w_shift;
    logic [DM_W+1:0]             w_diff;
    logic                        w_fit;

    assign w_num_abs = i_num[NUM_W-1] ? -i_num : i_num;
    assign w_den_abs = i_den[srg_pkg::DEN_W-1] ? -i_den : i_den;
    assign w_shift   = {r_pr, r_dvd[MAG_W-1]};
    assign w_diff    = {1'b0, w_shift} - {2'b00, r_dsr};
    assign w_fit     = !w_diff[DM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= w_num_abs[MAG_W-1:0];
            r_dsr  <= w_den_abs[DM_W-1:0];
            r_pr   <= '0;
            r_qneg <= i_num[NUM_W-1] ^ i_den[srg_pkg::DEN_W-1];
            r_rneg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MAG_W-2:0], w_fit};
            r_pr  <= w_fit ? w_diff[DM_W-1:0] : w_shift[DM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
    assign o_rem  = r_rneg ? -$signed({1'b0, r_pr}) : $signed({1'b0, r_pr});

endmodule

// ----- hdl/stepper_ramp_generator.sv -----
// ----------------------------------------------------------------------------
// stepper_ramp_generator: linear speed ramp for a stepper motor
// An item that causes no ramp divide passes S_EVAL and S_OUT before the next
// acceptance. An item that steps while accelerating or decelerating also runs
// the shared serial divider in S_DIV and S_FIN. No new item is accepted until
// the sequence is back in S_IDLE, and S_OUT waits while the output is stalled.
// Synchronous active-low reset restores the configuration defaults and clears all motion state and the output valid.
// ----------------------------------------------------------------------------
module stepper_ramp_generator #(
    parameter int DELAY_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_start_move,
    input  logic                            i_tick,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_step_taken,
    output logic [3:0]                      o_coil_pattern,
    output logic                            o_direction_level,
    output logic                            o_move_done,
    output logic                            o_busy_res,
    output logic [15:0]                     o_position,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int DW    = DELAY_WIDTH;
    localparam int NUM_W = ((DW > 27) ? DW : 27) + 3;
    localparam int ND_W  = NUM_W + 1;
    localparam int REM_W = srg_pkg::REM_W;
    localparam logic [32:0]     DMAX33 = (33'd1 << DW) - 33'd1;
    localparam logic [ND_W-1:0] ND_MAX = ND_W'(DMAX33);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] RS_STOP  = 2'd0;
    localparam logic [1:0] RS_ACCEL = 2'd1;
    localparam logic [1:0] RS_RUN   = 2'd2;
    localparam logic [1:0] RS_DECEL = 2'd3;

    srg_pkg::t_cfg            w_cfg;

    logic [2:0]               r_seq;
    logic [1:0]               r_rstate;
    logic                     r_moving;
    logic [DW-1:0]            r_cur;
    logic signed [REM_W-1:0]  r_rem;
    logic signed [24:0]       r_rc;
    logic [23:0]              r_steps;
    logic signed [24:0]       r_dstart;
    logic [DW-1:0]            r_last;
    logic [15:0]              r_pos;
    logic [DW-1:0]            r_elapsed;
    logic                     r_stepped;
    logic                     r_done;

    logic                     r_ovalid;
    logic                     r_o_step;
    logic [3:0]               r_o_coil;
    logic                     r_o_dir;
    logic                     r_o_done;
    logic                     r_o_busy;
    logic [15:0]              r_o_pos;

    logic [32:0]              w_min_ext;
    logic [32:0]              w_init_ext;
    logic [DW-1:0]            w_minv;
    logic [DW-1:0]            w_initv;
    logic                     w_accept;
    logic                     w_fire;
    logic                     w_ramping;
    logic                     w_div_start;
    logic                     w_div_done;
    logic                     w_out_free;
    logic [23:0]              w_steps_inc;
    logic signed [24:0]       w_rc_inc;
    logic [15:0]              w_pos_next;
    logic [16:0]              w_pos_up;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [srg_pkg::DEN_W-1:0] w_den;
    logic signed [NUM_W-1:0]  w_quot;
    logic signed [REM_W-1:0]  w_drem;
    logic signed [ND_W-1:0]   w_nd;
    logic [ND_W-1:0]          w_nd_mag;
    logic [DW-1:0]            w_nd_store;
    logic                     w_nd_le_min;
    logic                     w_ge_dstart;
    logic                     w_ge_dstart_inc;

    srg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    srg_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   (w_drem)
    );

    assign w_min_ext  = {9'd0, w_cfg.min_step_delay};
    assign w_init_ext = {9'd0, w_cfg.initial_step_delay};
    assign w_minv     = (w_min_ext > DMAX33) ? '1 : w_min_ext[DW-1:0];
    assign w_initv    = (w_init_ext > DMAX33) ? '1 : w_init_ext[DW-1:0];

    assign o_stall     = (r_seq != S_IDLE);
    assign w_accept    = i_valid && (r_seq == S_IDLE);
    assign w_fire      = r_moving && (r_elapsed >= r_cur);
    assign w_ramping   = (r_rstate == RS_ACCEL) || (r_rstate == RS_DECEL);
    assign w_div_start = (r_seq == S_EVAL) && w_fire && w_ramping;
    assign w_out_free  = !r_ovalid || !i_stall;

    assign w_steps_inc = r_steps + 24'd1;
    assign w_rc_inc    = r_rc + 25'sd1;

    assign w_num = $signed({{(NUM_W-DW-1){1'b0}}, r_cur, 1'b0})
                 + $signed({{(NUM_W-REM_W){r_rem[REM_W-1]}}, r_rem});
    assign w_den = $signed({w_rc_inc, 2'b01});

    assign w_nd        = $signed(ND_W'(r_cur)) - $signed({w_quot[NUM_W-1], w_quot});
    assign w_nd_mag    = w_nd[ND_W-1] ? ND_W'(-w_nd) : ND_W'(w_nd);
    assign w_nd_store  = (w_nd_mag > ND_MAX) ? '1 : w_nd_mag[DW-1:0];
    assign w_nd_le_min = (w_nd <= $signed(ND_W'(w_minv)));

    assign w_ge_dstart     = $signed({2'b00, r_steps}) >= $signed({r_dstart[24], r_dstart});
    assign w_ge_dstart_inc = $signed({2'b00, w_steps_inc}) >= $signed({r_dstart[24], r_dstart});

    assign w_pos_up = {1'b0, r_pos} + 17'd1;

    always_comb begin
        if (w_cfg.steps_per_rev == 16'd0) begin
            w_pos_next = 16'd0;
        end else if (!w_cfg.move_direction) begin
            w_pos_next = (w_pos_up >= {1'b0, w_cfg.steps_per_rev}) ? 16'd0 : w_pos_up[15:0];
        end else begin
            w_pos_next = (r_pos == 16'd0) ? (w_cfg.steps_per_rev - 16'd1) : (r_pos - 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= S_IDLE;
            r_rstate  <= RS_STOP;
            r_moving  <= 1'b0;
            r_cur     <= '0;
            r_rem     <= '0;
            r_rc      <= '0;
            r_steps   <= '0;
            r_dstart  <= '0;
            r_last    <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_stepped <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            unique case (r_seq)
                S_IDLE: begin
                    if (w_accept) begin
                        r_stepped <= 1'b0;
                        r_done    <= 1'b0;
                        r_seq     <= S_EVAL;
                        if (i_start_move) begin
                            r_pos   <= '0;
                            r_last  <= '0;
                            r_steps <= '0;
                            r_rem   <= '0;
                            r_rc    <= '0;
                            if (w_cfg.decel_offset == 25'sd0) begin
                                r_cur    <= w_minv;
                                r_dstart <= $signed({1'b0, w_cfg.move_length});
                                r_rstate <= RS_RUN;
                                r_moving <= 1'b1;
                            end else if (w_cfg.move_length == 24'd1) begin
                                r_rc     <= '1;
                                r_rstate <= RS_DECEL;
                                r_cur    <= w_minv;
                                r_moving <= 1'b1;
                            end else if (w_cfg.move_length != 24'd0) begin
                                r_dstart <= $signed({1'b0, w_cfg.move_length})
                                          + w_cfg.decel_offset;
                                r_moving <= 1'b1;
                                if (w_initv <= w_minv) begin
                                    r_cur    <= w_minv;
                                    r_rstate <= RS_RUN;
                                end else begin
                                    r_cur    <= w_initv;
                                    r_rstate <= RS_ACCEL;
                                end
                            end else begin
                                r_moving <= 1'b0;
                                r_rstate <= RS_STOP;
                            end
                        end
                        if (i_tick && (r_elapsed != '1)) begin
                            r_elapsed <= r_elapsed + DW'(1);
                        end
                    end
                end
                S_EVAL: begin
                    r_seq <= S_OUT;
                    if (w_fire) begin
                        r_elapsed <= '0;
                        unique case (r_rstate)
                            RS_ACCEL, RS_DECEL: begin
                                r_steps   <= w_steps_inc;
                                r_pos     <= w_pos_next;
                                r_stepped <= 1'b1;
                                r_rc      <= w_rc_inc;
                                r_seq     <= S_DIV;
                            end
                            RS_RUN: begin
                                r_steps   <= w_steps_inc;
                                r_pos     <= w_pos_next;
                                r_stepped <= 1'b1;
                                if (w_steps_inc >= w_cfg.move_length) begin
                                    r_cur    <= w_minv;
                                    r_rstate <= RS_STOP;
                                end else if (w_ge_dstart_inc) begin
                                    r_rc     <= w_cfg.decel_offset;
                                    r_cur    <= r_last;
                                    r_rstate <= RS_DECEL;
                                end else begin
                                    r_cur <= w_minv;
                                end
                            end
                            default: begin
                                r_steps  <= '0;
                                r_rem    <= '0;
                                r_done   <= 1'b1;
                                r_moving <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_seq <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_seq <= S_OUT;
                    r_rem <= w_drem;
                    r_cur <= w_nd_store;
                    if (r_rstate == RS_ACCEL) begin
                        if (w_ge_dstart) begin
                            r_rc     <= w_cfg.decel_offset;
                            r_rstate <= RS_DECEL;
                            r_rem    <= '0;
                        end else if (w_nd_le_min) begin
                            r_last   <= w_nd_store;
                            r_cur    <= w_minv;
                            r_rem    <= '0;
                            r_rstate <= RS_RUN;
                        end
                    end else if (!r_rc[24]) begin
                        r_rstate <= RS_STOP;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_seq <= S_IDLE;
                    end
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_seq == S_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_seq == S_OUT) && w_out_free) begin
            r_o_step <= r_stepped;
            r_o_coil <= srg_pkg::coil_pattern(w_cfg.interface_mode, r_pos[1:0]);
            r_o_dir  <= (w_cfg.interface_mode == srg_pkg::MODE_DRIVER)
                        ? w_cfg.move_direction : 1'b0;
            r_o_done <= r_done;
            r_o_busy <= r_moving;
            r_o_pos  <= r_pos;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_step_taken      = r_o_step;
    assign o_coil_pattern    = r_o_coil;
    assign o_direction_level = r_o_dir;
    assign o_move_done       = r_o_done;
    assign o_busy_res        = r_o_busy;
    assign o_position        = r_o_pos;

endmodule

// ----- hdl/srg_chk.sv -----
// ----------------------------------------------------------------------------
// srg_chk: port-level checks for the stepper ramp generator
// Watches the beats on both channels and the consistency of the flags.
// ----------------------------------------------------------------------------
module srg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_step_taken,
    input logic        o_move_done,
    input logic        o_busy_res,
    input logic [15:0] o_position
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_position)
                                  && $stable(o_step_taken) && $stable(o_move_done)))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted again before the previous beat was processed");

    a_step_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_step_taken) |-> (o_busy_res && !o_move_done))
        else $error("step reported outside a running move");

    a_done_ends_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_move_done) |-> !o_busy_res)
        else $error("move reported done while still busy");

endmodule

bind stepper_ramp_generator srg_chk u_srg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_step_taken (o_step_taken),
    .o_move_done  (o_move_done),
    .o_busy_res   (o_busy_res),
    .o_position   (o_position)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the stepper ramp generator
// Feeds start and tick beats, predicts every result beat from an independent
// model of the linear speed ramp and compares it field by field, with random
// input gaps, random output stalls and register settings changed between moves.
// ----------------------------------------------------------------------------
module tb_top;
    import srg_pkg::*;

    localparam longint DLY_MAX = 64'd16777215;
    localparam logic [15:0] TWO_WIRE_SEQ  = {4'd0, 4'd1, 4'd3, 4'd2};
    localparam logic [15:0] FOUR_WIRE_SEQ = {4'd9, 4'd10, 4'd6, 4'd5};

    typedef enum logic [1:0] {PH_STOP, PH_ACCEL, PH_RUN, PH_DECEL} ramp_phase_e;

    typedef struct {
        logic        step;
        logic [3:0]  coil;
        logic        dir_lvl;
        logic        done;
        logic        busy;
        logic [15:0] pos;
    } motor_out_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_start_move;
    logic                  i_tick;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_step_taken;
    logic [3:0]            o_coil_pattern;
    logic                  o_direction_level;
    logic                  o_move_done;
    logic                  o_busy_res;
    logic [15:0]           o_position;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    t_cfg        regs;
    ramp_phase_e phase;
    bit          moving;
    longint      cur_dly;
    longint      rem_acc;
    longint      ramp_cnt;
    longint      steps_done;
    longint      dec_step;
    longint      last_dly;
    longint      pos;
    longint      ticks;
    motor_out_t  pending_outputs[$];
    int          n_fail;
    int          sent_beats;

    stepper_ramp_generator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_move      (i_start_move),
        .i_tick            (i_tick),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_step_taken      (o_step_taken),
        .o_coil_pattern    (o_coil_pattern),
        .o_direction_level (o_direction_level),
        .o_move_done       (o_move_done),
        .o_busy_res        (o_busy_res),
        .o_position        (o_position),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #24_000_000;
        $display("stepper_ramp_generator regression: fail");
        $finish;
    end

    function automatic longint wrap25(input longint v);
        logic signed [24:0] t;
        t = v[24:0];
        return t;
    endfunction

    function automatic longint mag_sat(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return (m > DLY_MAX) ? DLY_MAX : m;
    endfunction

    function automatic longint recur_delay();
        longint dv;
        longint num;
        longint nd;
        dv = 4 * ramp_cnt + 1;
        num = 2 * cur_dly + rem_acc;
        nd = cur_dly - num / dv;
        rem_acc = num % dv;
        return nd;
    endfunction

    function automatic void step_motor();
        longint spr;
        spr = regs.steps_per_rev;
        if (spr == 0) begin
            pos = 0;
        end else if (!regs.move_direction) begin
            pos = pos + 1;
            if (pos >= spr) pos = 0;
        end else begin
            if (pos == 0) pos = spr;
            pos = (pos - 1) & 64'hFFFF;
        end
        steps_done = (steps_done + 1) & 64'hFFFFFF;
    endfunction

    function automatic void advance_ramp(input bit start, input bit tk);
        longint     minv;
        longint     off;
        longint     len;
        longint     nd;
        logic [1:0] q;
        motor_out_t res;
        minv = regs.min_step_delay;
        off = wrap25(regs.decel_offset);
        len = regs.move_length;
        res.step = 1'b0;
        res.done = 1'b0;
        if (start) begin
            pos = 0;
            last_dly = 0;
            steps_done = 0;
            rem_acc = 0;
            ramp_cnt = 0;
            if (off == 0) begin
                cur_dly = minv;
                dec_step = len;
                phase = PH_RUN;
                moving = 1'b1;
            end else if (len == 1) begin
                ramp_cnt = -1;
                phase = PH_DECEL;
                cur_dly = minv;
                moving = 1'b1;
            end else if (len != 0) begin
                dec_step = wrap25(len + off);
                cur_dly = regs.initial_step_delay;
                if (cur_dly <= minv) begin
                    cur_dly = minv;
                    phase = PH_RUN;
                end else begin
                    phase = PH_ACCEL;
                end
                moving = 1'b1;
            end else begin
                moving = 1'b0;
                phase = PH_STOP;
            end
        end
        if (tk && ticks < DLY_MAX) ticks++;
        if (moving && ticks >= cur_dly) begin
            ticks = 0;
            case (phase)
                PH_ACCEL: begin
                    step_motor();
                    res.step = 1'b1;
                    ramp_cnt = wrap25(ramp_cnt + 1);
                    nd = recur_delay();
                    if (steps_done >= dec_step) begin
                        ramp_cnt = off;
                        phase = PH_DECEL;
                        rem_acc = 0;
                    end else if (nd <= minv) begin
                        last_dly = mag_sat(nd);
                        nd = minv;
                        rem_acc = 0;
                        phase = PH_RUN;
                    end
                    cur_dly = mag_sat(nd);
                end
                PH_RUN: begin
                    step_motor();
                    res.step = 1'b1;
                    nd = minv;
                    if (steps_done >= len) begin
                        phase = PH_STOP;
                    end else if (steps_done >= dec_step) begin
                        ramp_cnt = off;
                        nd = last_dly;
                        phase = PH_DECEL;
                    end
                    cur_dly = mag_sat(nd);
                end
                PH_DECEL: begin
                    step_motor();
                    res.step = 1'b1;
                    ramp_cnt = wrap25(ramp_cnt + 1);
                    nd = recur_delay();
                    if (ramp_cnt >= 0) phase = PH_STOP;
                    cur_dly = mag_sat(nd);
                end
                default: begin
                    steps_done = 0;
                    rem_acc = 0;
                    res.done = 1'b1;
                    moving = 1'b0;
                end
            endcase
        end
        q = pos[1:0];
        res.coil = 4'd0;
        res.dir_lvl = 1'b0;
        case (regs.interface_mode)
            MODE_DRIVER:    res.dir_lvl = regs.move_direction;
            MODE_TWO_WIRE:  res.coil = TWO_WIRE_SEQ[q*4 +: 4];
            MODE_FOUR_WIRE: res.coil = FOUR_WIRE_SEQ[q*4 +: 4];
            default:        res.coil = 4'd0;
        endcase
        res.busy = moving;
        res.pos = pos[15:0];
        pending_outputs.push_back(res);
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        motor_out_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                $error("result beat with no expectation waiting");
                n_fail++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("step_taken", want.step, o_step_taken);
                check_field("coil_pattern", want.coil, o_coil_pattern);
                check_field("direction_level", want.dir_lvl, o_direction_level);
                check_field("move_done", want.done, o_move_done);
                check_field("busy_res", want.busy, o_busy_res);
                check_field("position", want.pos, o_position);
            end
        end
    end

    initial begin : out_stall_gen
        int run_len;
        int hold_len;
        i_stall = 1'b0;
        forever begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(negedge i_clk);
            hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 3);
            i_stall <= 1'b1;
            repeat (hold_len) @(negedge i_clk);
            i_stall <= 1'b0;
        end
    end

    task automatic send_beat(input bit start, input bit tk);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
            : (r < 98) ? $urandom_range(4, 10) : $urandom_range(20, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_start_move <= start;
        i_tick <= tk;
        do @(posedge i_clk); while (o_stall);
        advance_ramp(start, tk);
        sent_beats++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:      regs.interface_mode = val[1:0];
            REG_SPR:       regs.steps_per_rev = val[15:0];
            REG_DIR:       regs.move_direction = val[0];
            REG_LENGTH:    regs.move_length = val[23:0];
            REG_MIN_DELAY: regs.min_step_delay = val[23:0];
            REG_INIT_DLY:  regs.initial_step_delay = val[23:0];
            REG_DEC_OFF:   regs.decel_offset = val[24:0];
            default:       regs = regs;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(input logic [1:0] mode, input logic [15:0] spr,
                               input logic dir, input logic [23:0] len,
                               input logic [23:0] mind, input logic [23:0] initd,
                               input logic [24:0] off);
        drain_results();
        set_reg(REG_MODE, {30'd0, mode});
        set_reg(REG_SPR, {16'd0, spr});
        set_reg(REG_DIR, {31'd0, dir});
        set_reg(REG_LENGTH, {8'd0, len});
        set_reg(REG_MIN_DELAY, {8'd0, mind});
        set_reg(REG_INIT_DLY, {8'd0, initd});
        set_reg(REG_DEC_OFF, {{7{off[24]}}, off});
    endtask

    task automatic run_move(input int cap, input int noise_pct);
        int n;
        int r;
        send_beat(1'b1, 1'b1);
        n = 0;
        while (moving && n < cap) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct / 4) send_beat(1'b1, $urandom_range(0, 1));
            else if (r < noise_pct) send_beat(1'b0, 1'b0);
            else send_beat(1'b0, 1'b1);
            n++;
        end
    endtask

    task automatic test_unramped_move();
        load_config(MODE_DRIVER, 16'd0, 1'b1, 24'd0, 24'd1, 24'd1000, 0);
        send_beat(1'b0, 1'b0);
        run_move(8, 0);
    endtask

    task automatic test_one_step_move();
        load_config(MODE_TWO_WIRE, 16'hFFFF, 1'b1, 24'd1, 24'd1, 24'd1, -1);
        run_move(8, 0);
    endtask

    task automatic test_flat_ramp();
        load_config(MODE_FOUR_WIRE, 16'd1, 1'b0, 24'd3, 24'd2, 24'd1, -1);
        run_move(20, 0);
    endtask

    task automatic test_empty_ramp();
        load_config(MODE_DRIVER, 16'd200, 1'b0, 24'd0, 24'd1, 24'd5, -3);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);
    endtask

    task automatic test_short_ramp();
        load_config(MODE_DRIVER, 16'd3, 1'b0, 24'd4, 24'd1, 24'd3, -2);
        run_move(40, 0);
    endtask

    task automatic test_offset_wrap();
        load_config(MODE_TWO_WIRE, 16'd5, 1'b1, 24'hFFFFFF, 24'd1, 24'd2, 1);
        run_move(20, 0);
    endtask

    task automatic test_register_extremes();
        load_config(MODE_FOUR_WIRE, 16'hFFFF, 1'b0, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF, -16777215);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);
        drain_results();
        set_reg(REG_LENGTH, 32'd0);
        send_beat(1'b1, 1'b0);
    endtask

    task automatic test_random_moves();
        int target;
        int len;
        int mind;
        int initd;
        int sel;
        int off;
        target = sent_beats + 600;
        while (sent_beats < target) begin
            len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            mind = $urandom_range(1, 4);
            initd = ($urandom_range(0, 4) == 0) ? $urandom_range(1, mind)
                                                : mind + $urandom_range(0, 15);
            sel = $urandom_range(0, 19);
            off = (sel < 4) ? 0 : (sel < 19) ? -int'($urandom_range(1, len + 2))
                                             : -int'($urandom_range(1, 16777215));
            load_config($urandom_range(0, 2),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                    : $urandom_range(1, 12),
                        $urandom_range(0, 1), len, mind, initd, off);
            run_move(400, 15);
            repeat ($urandom_range(0, 3))
                send_beat($urandom_range(0, 7) == 0, $urandom_range(0, 1));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_start_move = 1'b0;
        i_tick = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_fail = 0;
        sent_beats = 0;
        regs.interface_mode = MODE_DRIVER;
        regs.steps_per_rev = 16'd200;
        regs.move_direction = 1'b0;
        regs.move_length = 24'd0;
        regs.min_step_delay = 24'd1000;
        regs.initial_step_delay = 24'd1000;
        regs.decel_offset = '0;
        phase = PH_STOP;
        moving = 1'b0;
        cur_dly = 0;
        rem_acc = 0;
        ramp_cnt = 0;
        steps_done = 0;
        dec_step = 0;
        last_dly = 0;
        pos = 0;
        ticks = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_unramped_move();
        test_one_step_move();
        test_flat_ramp();
        test_empty_ramp();
        test_short_ramp();
        test_offset_wrap();
        test_register_extremes();
        test_random_moves();
        drain_results();
        if (n_fail == 0 && pending_outputs.size() == 0) begin
            $display("stepper_ramp_generator regression: pass");
        end else begin
            $display("stepper_ramp_generator regression: fail");
        end
        $finish;
    end

endmodule

// ----- stepper_ramp_generator.f -----
hdl/srg_pkg.sv
hdl/srg_cfg.sv
hdl/srg_div.sv
hdl/stepper_ramp_generator.sv
hdl/srg_chk.sv
bench/tb_top.sv
